// File: src/fixed_point_q24_8_alu_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Q24.8 ALU
// Clocked on i_clk and disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef FIXED_POINT_Q24_8_ALU_UNIT_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define FXALU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("fxalu assertion failed");
`define FXALU_NEVER(lbl, expr) \
    `FXALU_ASSERT(lbl, !(expr))
`else
`define FXALU_ASSERT(lbl, prop)
`define FXALU_NEVER(lbl, expr)
`endif

`endif

// File: src/fxalu_pkg.sv
// ---------------------------------------------------------------------------
// fxalu_pkg
// Shared constants, types and helpers of the Q24.8 ALU.
// ---------------------------------------------------------------------------
package fxalu_pkg;

    localparam int VALUE_W      = 32;
    localparam int FRAC_W       = 8;
    localparam int OP_W         = 4;
    localparam int QUO_W        = VALUE_W + FRAC_W;
    localparam int NSTG         = QUO_W + 3;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 4'd3;
    localparam logic [OP_W-1:0] OP_MIN  = 4'd4;
    localparam logic [OP_W-1:0] OP_MAX  = 4'd5;
    localparam logic [OP_W-1:0] OP_CMP  = 4'd6;
    localparam logic [OP_W-1:0] OP_INC  = 4'd7;
    localparam logic [OP_W-1:0] OP_DEC  = 4'd8;
    localparam logic [OP_W-1:0] OP_FROM = 4'd9;
    localparam logic [OP_W-1:0] OP_TO   = 4'd10;

    typedef enum logic [3:0] {
        CL_ADD, CL_MUL, CL_DIV, CL_MIN, CL_MAX, CL_FROM, CL_TO, CL_ZERO
    } t_class;

    typedef struct packed {
        t_class             cls;
        logic [VALUE_W-1:0] a;
        logic [VALUE_W-1:0] b;
        logic [VALUE_W:0]   addend;
        logic               lt;
        logic               eq;
        logic               gt;
    } t_item;

    typedef struct packed {
        t_class               cls;
        logic                 neg;
        logic [VALUE_W-1:0]   res;
        logic                 lt;
        logic                 eq;
        logic                 gt;
        logic                 ovf;
        logic                 dbz;
        logic [2*VALUE_W-1:0] prod;
        logic [VALUE_W-1:0]   mb;
        logic [VALUE_W-1:0]   rem;
        logic [QUO_W-1:0]     num;
    } t_stage;

    typedef struct packed {
        logic [VALUE_W-1:0] val;
        logic               ovf;
    } t_packed;

    // sign and magnitude to a raw word, saturating at the signed bounds
    function automatic t_packed sat_pack(input logic neg, input logic [63:0] mag);
        logic [63:0] lim;
        logic [63:0] m;
        t_packed     r;
        lim   = 64'(1) << (VALUE_W - 1);
        if (!neg) begin
            lim = lim - 64'(1);
        end
        m     = mag;
        r.ovf = 1'b0;
        if (mag > lim) begin
            m     = lim;
            r.ovf = 1'b1;
        end
        r.val = neg ? (~m[VALUE_W-1:0] + VALUE_W'(1)) : m[VALUE_W-1:0];
        return r;
    endfunction

endpackage

// File: src/fxalu_front.sv
// ---------------------------------------------------------------------------
// fxalu_front
// Decodes the operation into a class, builds the addend and compare flags.
// ---------------------------------------------------------------------------
module fxalu_front
    import fxalu_pkg::*;
(
    input  logic [OP_W-1:0]    i_operation,
    input  logic [VALUE_W-1:0] i_operand_a,
    input  logic [VALUE_W-1:0] i_operand_b,
    output t_item              o_item
);

    logic [VALUE_W:0] w_bext;

    assign w_bext = {i_operand_b[VALUE_W-1], i_operand_b};

    always_comb begin
        o_item.a      = i_operand_a;
        o_item.b      = i_operand_b;
        o_item.lt     = $signed(i_operand_a) < $signed(i_operand_b);
        o_item.eq     = i_operand_a == i_operand_b;
        o_item.gt     = $signed(i_operand_a) > $signed(i_operand_b);
        o_item.addend = w_bext;
        unique case (i_operation)
            OP_ADD:  o_item.cls = CL_ADD;
            OP_SUB: begin
                o_item.cls    = CL_ADD;
                o_item.addend = ~w_bext + (VALUE_W+1)'(1);
            end
            OP_INC: begin
                o_item.cls    = CL_ADD;
                o_item.addend = (VALUE_W+1)'(1);
            end
            OP_DEC: begin
                o_item.cls    = CL_ADD;
                o_item.addend = '1;
            end
            OP_MUL:  o_item.cls = CL_MUL;
            OP_DIV:  o_item.cls = CL_DIV;
            OP_MIN:  o_item.cls = CL_MIN;
            OP_MAX:  o_item.cls = CL_MAX;
            OP_FROM: o_item.cls = CL_FROM;
            OP_TO:   o_item.cls = CL_TO;
            OP_CMP:  o_item.cls = CL_ZERO;
            default: o_item.cls = CL_ZERO;
        endcase
    end

endmodule

// File: src/fxalu_queue.sv
// ---------------------------------------------------------------------------
// fxalu_queue
// Small flop-based FIFO between the decode front and the execute back.
// ---------------------------------------------------------------------------
module fxalu_queue
    import fxalu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_nempty,
    output t_item o_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0]  r_count, n_count;
    logic           w_push, w_pop;

    assign o_full   = r_count == CW'(DEPTH);
    assign o_nempty = r_count != '0;
    assign o_item   = r_mem[r_rp];
    assign w_push   = i_push && !o_full;
    assign w_pop    = i_pop && o_nempty;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (w_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (w_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

`include "fixed_point_q24_8_alu_unit_assert.svh"
    `FXALU_ASSERT(a_count_bound, r_count <= CW'(DEPTH))
    `FXALU_ASSERT(a_count_track, (w_push && !w_pop) |=> r_count == $past(r_count) + CW'(1))

endmodule

// File: src/fxalu_back.sv
// ---------------------------------------------------------------------------
// fxalu_back
// Execute pipeline: operand stage, multiply finish, one stage per quotient
// bit of the restoring divider, then rounding of the quotient.
// ---------------------------------------------------------------------------
module fxalu_back
    import fxalu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_nempty,
    input  t_item              i_item,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [VALUE_W-1:0] o_result_value,
    output logic               o_a_less,
    output logic               o_a_equal,
    output logic               o_a_greater,
    output logic               o_overflow_flag,
    output logic               o_divide_by_zero
);

    localparam logic signed [VALUE_W+1:0] SMAX = (VALUE_W+2)'((64'(1) << (VALUE_W-1)) - 1);
    localparam logic signed [VALUE_W+1:0] SMIN = -SMAX - (VALUE_W+2)'(1);

    logic [NSTG-1:0] r_vld, n_vld;
    t_stage          r_stg [NSTG];
    t_stage          n_stg [NSTG];
    logic            w_en;

    // one quotient bit of restoring division
    function automatic t_stage div_step(input t_stage s);
        logic [VALUE_W:0] t;
        t_stage           r;
        r = s;
        t = {s.rem, s.num[QUO_W-1]};
        if (t >= {1'b0, s.mb}) begin
            r.rem = VALUE_W'(t - {1'b0, s.mb});
            r.num = {s.num[QUO_W-2:0], 1'b1};
        end else begin
            r.rem = t[VALUE_W-1:0];
            r.num = {s.num[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

    assign w_en  = !r_vld[NSTG-1] || i_ready;
    assign o_pop = w_en;
    assign n_vld = {r_vld[NSTG-2:0], i_nempty};

    // operand stage
    logic [VALUE_W-1:0]        w_ma, w_mb;
    logic signed [VALUE_W+1:0] w_sum;
    logic [VALUE_W+FRAC_W-1:0] w_shl;
    logic [FRAC_W:0]           w_top;
    always_comb begin
        w_ma  = i_item.a[VALUE_W-1] ? (~i_item.a + VALUE_W'(1)) : i_item.a;
        w_mb  = i_item.b[VALUE_W-1] ? (~i_item.b + VALUE_W'(1)) : i_item.b;
        w_sum = $signed({i_item.a[VALUE_W-1], i_item.a[VALUE_W-1], i_item.a})
              + $signed({i_item.addend[VALUE_W], i_item.addend});
        w_shl = {i_item.a, FRAC_W'(0)};
        w_top = w_shl[VALUE_W+FRAC_W-1:VALUE_W-1];

        n_stg[0].cls  = i_item.cls;
        n_stg[0].neg  = i_item.a[VALUE_W-1] ^ i_item.b[VALUE_W-1];
        n_stg[0].lt   = i_item.lt;
        n_stg[0].eq   = i_item.eq;
        n_stg[0].gt   = i_item.gt;
        n_stg[0].dbz  = (i_item.cls == CL_DIV) && (i_item.b == '0);
        n_stg[0].prod = w_ma * w_mb;
        n_stg[0].mb   = w_mb;
        n_stg[0].rem  = '0;
        n_stg[0].num  = {w_ma, FRAC_W'(0)};
        n_stg[0].ovf  = 1'b0;
        n_stg[0].res  = '0;
        case (i_item.cls)
            CL_ADD: begin
                if (w_sum > SMAX) begin
                    n_stg[0].res = SMAX[VALUE_W-1:0];
                    n_stg[0].ovf = 1'b1;
                end else if (w_sum < SMIN) begin
                    n_stg[0].res = SMIN[VALUE_W-1:0];
                    n_stg[0].ovf = 1'b1;
                end else begin
                    n_stg[0].res = w_sum[VALUE_W-1:0];
                end
            end
            CL_MIN: n_stg[0].res = i_item.lt ? i_item.a : i_item.b;
            CL_MAX: n_stg[0].res = i_item.gt ? i_item.a : i_item.b;
            CL_FROM: begin
                if ((&w_top) || !(|w_top)) begin
                    n_stg[0].res = w_shl[VALUE_W-1:0];
                end else begin
                    n_stg[0].res = i_item.a[VALUE_W-1] ? SMIN[VALUE_W-1:0]
                                                        : SMAX[VALUE_W-1:0];
                    n_stg[0].ovf = 1'b1;
                end
            end
            CL_TO:   n_stg[0].res = VALUE_W'($signed(i_item.a) >>> FRAC_W);
            default: n_stg[0].res = '0;
        endcase
    end

    // multiply finish: round half away from zero on the magnitude, then pack
    logic [2*VALUE_W:0] w_rnd;
    t_packed            w_mpk;
    always_comb begin
        w_rnd = {1'b0, r_stg[0].prod} + (2*VALUE_W+1)'((64'(1) << FRAC_W) >> 1);
        w_mpk = sat_pack(r_stg[0].neg, 64'(w_rnd >> FRAC_W));
        n_stg[1] = r_stg[0];
        if (r_stg[0].cls == CL_MUL) begin
            n_stg[1].res = w_mpk.val;
            n_stg[1].ovf = w_mpk.ovf;
        end
    end

    for (genvar k = 2; k < NSTG - 1; k++) begin : g_div
        always_comb begin
            n_stg[k] = div_step(r_stg[k-1]);
        end
    end

    // quotient rounding: bump when twice the remainder reaches the divisor
    logic [QUO_W:0] w_q;
    t_packed        w_dpk;
    always_comb begin
        w_q = {1'b0, r_stg[NSTG-2].num}
            + (QUO_W+1)'({r_stg[NSTG-2].rem, 1'b0} >= {1'b0, r_stg[NSTG-2].mb});
        w_dpk = sat_pack(r_stg[NSTG-2].neg, 64'(w_q));
        n_stg[NSTG-1] = r_stg[NSTG-2];
        if (r_stg[NSTG-2].cls == CL_DIV) begin
            n_stg[NSTG-1].res = r_stg[NSTG-2].dbz ? '0 : w_dpk.val;
            n_stg[NSTG-1].ovf = r_stg[NSTG-2].dbz ? 1'b0 : w_dpk.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NSTG; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_valid          = r_vld[NSTG-1];
    assign o_result_value   = r_stg[NSTG-1].res;
    assign o_a_less         = r_stg[NSTG-1].lt;
    assign o_a_equal        = r_stg[NSTG-1].eq;
    assign o_a_greater      = r_stg[NSTG-1].gt;
    assign o_overflow_flag  = r_stg[NSTG-1].ovf;
    assign o_divide_by_zero = r_stg[NSTG-1].dbz;

`include "fixed_point_q24_8_alu_unit_assert.svh"
    `FXALU_ASSERT(a_flags_onehot, o_valid |-> $onehot({o_a_less, o_a_equal, o_a_greater}))
    `FXALU_ASSERT(a_dbz_zero, (o_valid && o_divide_by_zero) |-> (o_result_value == '0 && !o_overflow_flag))
    `FXALU_ASSERT(a_stall_hold, !w_en |=> $stable(r_vld))

endmodule

// File: src/fixed_point_q24_8_alu_unit.sv
// ---------------------------------------------------------------------------
// fixed_point_q24_8_alu_unit
// Q24.8 ALU: decode front, item queue, pipelined execute back.
// ---------------------------------------------------------------------------
//  channel | handshake           | payload
//  in      | i_valid / o_ready   | i_operation, i_operand_a, i_operand_b
//  out     | o_valid / i_ready   | o_result_value, o_a_less, o_a_equal,
//          |                     | o_a_greater, o_overflow_flag, o_divide_by_zero
//
// One beat per cycle in and out while the queue is not full and the output is
// not stalled. The 43 execute stages are set by the divider, which resolves
// one quotient bit per stage (40 bits). Reset clears the queue pointers and
// count and the stage valid bits only. A stall on the output freezes the whole
// execute pipeline; the queue keeps taking beats until it is full.
// ---------------------------------------------------------------------------
module fixed_point_q24_8_alu_unit
    import fxalu_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [VALUE_W-1:0] i_operand_a,
    input  logic [VALUE_W-1:0] i_operand_b,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [VALUE_W-1:0] o_result_value,
    output logic               o_a_less,
    output logic               o_a_equal,
    output logic               o_a_greater,
    output logic               o_overflow_flag,
    output logic               o_divide_by_zero
);

    t_item w_fitem, w_qitem;
    logic  w_full, w_nempty, w_pop;

    fxalu_front u_front (
        .i_operation (i_operation),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_item      (w_fitem)
    );

    fxalu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_valid),
        .i_item   (w_fitem),
        .o_full   (w_full),
        .i_pop    (w_pop),
        .o_nempty (w_nempty),
        .o_item   (w_qitem)
    );

    assign o_ready = !w_full;

    fxalu_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_nempty         (w_nempty),
        .i_item           (w_qitem),
        .o_pop            (w_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result_value   (o_result_value),
        .o_a_less         (o_a_less),
        .o_a_equal        (o_a_equal),
        .o_a_greater      (o_a_greater),
        .o_overflow_flag  (o_overflow_flag),
        .o_divide_by_zero (o_divide_by_zero)
    );

endmodule
